[rtl/fpsc_pkg.sv]
package fpsc_pkg;

	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 16;

	localparam logic [CfgAddrW-1:0] REG_TARGET   = 3'd0;
	localparam logic [CfgAddrW-1:0] REG_BEAM     = 3'd1;
	localparam logic [CfgAddrW-1:0] REG_CENTER   = 3'd2;
	localparam logic [CfgAddrW-1:0] REG_MAX_TILT = 3'd3;
	localparam logic [CfgAddrW-1:0] REG_GAIN_P   = 3'd4;
	localparam logic [CfgAddrW-1:0] REG_GAIN_I   = 3'd5;
	localparam logic [CfgAddrW-1:0] REG_GAIN_D   = 3'd6;
	localparam logic [CfgAddrW-1:0] REG_SMOOTH   = 3'd7;

	localparam logic [55:0] DIST_MUL    = 56'd287730;
	localparam logic [55:0] DIST_ROUND  = 56'd32768;
	localparam logic [17:0] MIN_DIST    = 18'd512;
	localparam logic [16:0] BEAM_SLACK  = 17'd1280;
	localparam logic signed [23:0] ISUM_LIMIT = 24'sd1310720;
	localparam logic [55:0] ISTEP_LIMIT = 56'd2621440;
	localparam logic [31:0] DEFAULT_DT  = 32'd20;
	localparam logic [31:0] MS_PER_S    = 32'd1000;
	localparam logic [8:0]  ONE_Q8      = 9'd256;

endpackage

[rtl/filtered_pid_servo_controller.sv]
// Ball-on-beam servo controller: converts an echo width to a Q8.8 distance,
// smooths it with an exponential moving average, runs PID on setpoint minus
// the filtered distance and returns a servo angle. One request is taken at a
// time; all products and quotients are formed one bit per cycle by a shared
// shift-add multiplier and a restoring divider. An invalid request (timeout
// or distance out of range) goes from the check straight to output; a valid
// one runs a 56-step integral divide, a 27-step derivative divide and three
// 16-step gain products, and the first valid one seeds the filter without
// the two 9-step smoothing products. A result waiting on the output holds
// the block in its output state; once the result is loaded, the next request
// can be taken in the following cycle, even while that result still waits on
// the output.
module filtered_pid_servo_controller #(
	parameter int ECHO_TIMEOUT_US = 30000
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [fpsc_pkg::CfgAddrW-1:0]  cfg_addr,
	input  logic [fpsc_pkg::CfgDataW-1:0]  cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [47:0]                    s_tdata,   // echo_width[14:0], time_ms[46:15]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [47:0]                    m_tdata,   // servo_angle[7:0], smoothed_distance[23:8],
	                                                  // position_error[40:24]
	output logic                           m_tuser    // ball_seen[0]
);
	import fpsc_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CONV  = 4'd1;
	localparam logic [3:0] ST_CHECK = 4'd2;
	localparam logic [3:0] ST_EMA_A = 4'd3;
	localparam logic [3:0] ST_EMA_B = 4'd4;
	localparam logic [3:0] ST_EMA_E = 4'd5;
	localparam logic [3:0] ST_PREP  = 4'd6;
	localparam logic [3:0] ST_IMUL  = 4'd7;
	localparam logic [3:0] ST_IDVL  = 4'd8;
	localparam logic [3:0] ST_IDIV  = 4'd9;
	localparam logic [3:0] ST_ISUM  = 4'd10;
	localparam logic [3:0] ST_DDIV  = 4'd11;
	localparam logic [3:0] ST_PIDP  = 4'd12;
	localparam logic [3:0] ST_GMUL  = 4'd13;
	localparam logic [3:0] ST_FIN   = 4'd14;
	localparam logic [3:0] ST_OUT   = 4'd15;

	localparam logic [16:0] TIMEOUT = 17'(ECHO_TIMEOUT_US);

	logic [15:0] target_q, beam_q, gain_p_q, gain_i_q, gain_d_q;
	logic [7:0]  center_q;
	logic [6:0]  max_tilt_q;
	logic [8:0]  smooth_q;

	logic [3:0]  state_q;
	logic [5:0]  cnt_q;
	logic [1:0]  gsel_q;
	logic [55:0] acc_q, mcand_q, dvd_q, quo_q;
	logic [15:0] mplier_q;
	logic        sub_q;
	logic [31:0] rem_q, div_q;
	logic [14:0] echo_q;
	logic [31:0] now_q, dt_q, ltime_q;
	logic [15:0] filt_q;
	logic        started_q;
	logic signed [21:0] esum_q;
	logic signed [16:0] e_q, lerr_q;
	logic [26:0] dq_q;
	logic        dsign_q, seen_q;
	logic [7:0]  langle_q;

	logic        m_tvalid_q, o_seen_q;
	logic [7:0]  o_angle_q;
	logic [15:0] o_dist_q;
	logic [16:0] o_err_q;

	logic [55:0] addend, acc_step;
	logic [32:0] trial;
	logic        ge;
	logic [17:0] dist_full;
	logic        meas_ok;
	logic [15:0] dist_sat;
	logic [8:0]  alpha;
	logic [31:0] dt_raw, dt_use;
	logic signed [16:0] e_new;
	logic [15:0] e_mag, e_mag_q;
	logic [21:0] istep;
	logic signed [23:0] nsum, nsum_c;
	logic signed [17:0] diff;
	logic [16:0] diff_mag;
	logic [26:0] dd;
	logic [20:0] esum_mag;
	logic signed [55:0] lim, sclamp;
	logic [55:0] smag;
	logic [6:0]  drv;
	logic signed [9:0] angle_raw;
	logic [7:0]  angle;
	logic        load_out;

	always_comb begin
		addend   = mplier_q[0] ? mcand_q : 56'd0;
		acc_step = sub_q ? acc_q - addend : acc_q + addend;
		trial    = {rem_q, dvd_q[55]};
		ge       = trial >= {1'b0, div_q};

		dist_full = acc_q[33:16];
		meas_ok   = (echo_q != 15'd0) && ({2'b0, echo_q} <= TIMEOUT) &&
			(dist_full >= MIN_DIST) && (dist_full <= {1'b0, {1'b0, beam_q} + BEAM_SLACK});
		dist_sat  = (dist_full > 18'd65535) ? 16'hFFFF : dist_full[15:0];
		alpha     = (smooth_q > ONE_Q8) ? ONE_Q8 : smooth_q;

		dt_raw = now_q - ltime_q;
		dt_use = (dt_raw == 32'd0) ? DEFAULT_DT : dt_raw;
		e_new  = $signed({1'b0, target_q}) - $signed({1'b0, filt_q});
		e_mag  = e_new[16] ? 16'(-e_new) : e_new[15:0];
		e_mag_q = e_q[16] ? 16'(-e_q) : e_q[15:0];

		istep  = (quo_q > ISTEP_LIMIT) ? ISTEP_LIMIT[21:0] : quo_q[21:0];
		nsum   = e_q[16] ? 24'(esum_q) - $signed({2'b0, istep})
			: 24'(esum_q) + $signed({2'b0, istep});
		if (nsum > ISUM_LIMIT) begin
			nsum_c = ISUM_LIMIT;
		end else if (nsum < -ISUM_LIMIT) begin
			nsum_c = -ISUM_LIMIT;
		end else begin
			nsum_c = nsum;
		end
		diff     = 18'(e_q) - 18'(lerr_q);
		diff_mag = diff[17] ? 17'(-diff) : diff[16:0];
		dd       = {diff_mag, 10'b0} - {6'b0, diff_mag, 4'b0} - {7'b0, diff_mag, 3'b0};
		esum_mag = esum_q[21] ? 21'(-esum_q) : esum_q[20:0];

		lim = $signed({25'b0, max_tilt_q, 24'b0});
		if ($signed(acc_q) > lim) begin
			sclamp = lim;
		end else if ($signed(acc_q) < -lim) begin
			sclamp = -lim;
		end else begin
			sclamp = $signed(acc_q);
		end
		smag = sclamp[55] ? 56'(-sclamp) : 56'(sclamp);
		drv  = smag[30:24];
		angle_raw = sclamp[55] ? $signed({2'b0, center_q}) + $signed({3'b0, drv})
			: $signed({2'b0, center_q}) - $signed({3'b0, drv});
		if (angle_raw < 0) begin
			angle = 8'd0;
		end else if (angle_raw > 10'sd180) begin
			angle = 8'd180;
		end else begin
			angle = angle_raw[7:0];
		end

		load_out = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= 16'd2816;
			beam_q     <= 16'd4608;
			center_q   <= 8'd51;
			max_tilt_q <= 7'd25;
			gain_p_q   <= 16'd589;
			gain_i_q   <= 16'd0;
			gain_d_q   <= 16'd154;
			smooth_q   <= 9'd51;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_TARGET:   target_q   <= cfg_wdata;
				REG_BEAM:     beam_q     <= cfg_wdata;
				REG_CENTER:   center_q   <= cfg_wdata[7:0];
				REG_MAX_TILT: max_tilt_q <= cfg_wdata[6:0];
				REG_GAIN_P:   gain_p_q   <= cfg_wdata;
				REG_GAIN_I:   gain_i_q   <= cfg_wdata;
				REG_GAIN_D:   gain_d_q   <= cfg_wdata;
				REG_SMOOTH:   smooth_q   <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			started_q  <= 1'b0;
			filt_q     <= 16'd0;
			esum_q     <= 22'sd0;
			lerr_q     <= 17'sd0;
			ltime_q    <= 32'd0;
			langle_q   <= 8'd51;
			m_tvalid_q <= 1'b0;
			cnt_q      <= 6'd0;
			gsel_q     <= 2'd0;
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						echo_q   <= s_tdata[14:0];
						now_q    <= s_tdata[46:15];
						acc_q    <= DIST_ROUND;
						mcand_q  <= DIST_MUL;
						mplier_q <= {1'b0, s_tdata[14:0]};
						sub_q    <= 1'b0;
						cnt_q    <= 6'd15;
						state_q  <= ST_CONV;
					end
				end
				ST_CONV, ST_EMA_A, ST_EMA_B, ST_IMUL, ST_GMUL: begin
					acc_q    <= acc_step;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						case (state_q)
							ST_CONV: state_q <= ST_CHECK;
							ST_EMA_A: begin
								mcand_q  <= {40'b0, filt_q};
								mplier_q <= {7'b0, ONE_Q8 - alpha};
								cnt_q    <= 6'd9;
								state_q  <= ST_EMA_B;
							end
							ST_EMA_B: state_q <= ST_EMA_E;
							ST_IMUL: state_q <= ST_IDVL;
							default: begin
								cnt_q <= 6'd16;
								if (gsel_q == 2'd0) begin
									mcand_q  <= {35'b0, esum_mag};
									mplier_q <= gain_i_q;
									sub_q    <= esum_q[21];
									gsel_q   <= 2'd1;
								end else if (gsel_q == 2'd1) begin
									mcand_q  <= {21'b0, dq_q, 8'b0};
									mplier_q <= gain_d_q;
									sub_q    <= dsign_q;
									gsel_q   <= 2'd2;
								end else begin
									state_q <= ST_FIN;
								end
							end
						endcase
					end
				end
				ST_CHECK: begin
					if (!meas_ok) begin
						seen_q  <= 1'b0;
						state_q <= ST_OUT;
					end else if (started_q) begin
						acc_q    <= 56'd128;
						mcand_q  <= {40'b0, dist_sat};
						mplier_q <= {7'b0, alpha};
						sub_q    <= 1'b0;
						cnt_q    <= 6'd9;
						state_q  <= ST_EMA_A;
					end else begin
						filt_q    <= dist_sat;
						started_q <= 1'b1;
						state_q   <= ST_PREP;
					end
				end
				ST_EMA_E: begin
					filt_q  <= acc_q[23:8];
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					dt_q     <= dt_use;
					ltime_q  <= now_q;
					e_q      <= e_new;
					acc_q    <= 56'd0;
					mcand_q  <= {24'b0, dt_use};
					mplier_q <= e_mag;
					sub_q    <= 1'b0;
					cnt_q    <= 6'd16;
					state_q  <= ST_IMUL;
				end
				ST_IDVL: begin
					dvd_q   <= {acc_q[47:0], 8'b0};
					rem_q   <= 32'd0;
					div_q   <= MS_PER_S;
					cnt_q   <= 6'd56;
					state_q <= ST_IDIV;
				end
				ST_IDIV, ST_DDIV: begin
					rem_q <= ge ? 32'(trial - {1'b0, div_q}) : trial[31:0];
					dvd_q <= dvd_q << 1;
					quo_q <= {quo_q[54:0], ge};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= (state_q == ST_IDIV) ? ST_ISUM : ST_PIDP;
					end
				end
				ST_ISUM: begin
					esum_q  <= nsum_c[21:0];
					dsign_q <= diff[17];
					lerr_q  <= e_q;
					dvd_q   <= {dd, 29'b0};
					rem_q   <= 32'd0;
					div_q   <= dt_q;
					cnt_q   <= 6'd27;
					state_q <= ST_DDIV;
				end
				ST_PIDP: begin
					dq_q     <= quo_q[26:0];
					acc_q    <= 56'd0;
					mcand_q  <= {32'b0, e_mag_q, 8'b0};
					mplier_q <= gain_p_q;
					sub_q    <= e_q[16];
					cnt_q    <= 6'd16;
					gsel_q   <= 2'd0;
					state_q  <= ST_GMUL;
				end
				ST_FIN: begin
					langle_q <= angle;
					seen_q   <= 1'b1;
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			o_seen_q  <= seen_q;
			o_angle_q <= langle_q;
			o_dist_q  <= filt_q;
			o_err_q   <= seen_q ? e_q : 17'd0;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, o_err_q, o_dist_q, o_angle_q};
	assign m_tuser  = o_seen_q;

`ifndef NO_ASSERTIONS
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_CONV)
		else $error("request not taken into conversion");
	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && (!m_tvalid_q || m_tready) |=> m_tvalid_q && state_q == ST_IDLE)
		else $error("result not loaded");
	a_isum: assert property (@(posedge clk) disable iff (!arst_n)
		(24'(esum_q) <= ISUM_LIMIT) && (24'(esum_q) >= -ISUM_LIMIT))
		else $error("integral outside limit");
	a_angle: assert property (@(posedge clk) disable iff (!arst_n)
		langle_q <= 8'd180)
		else $error("angle above range");
`endif

endmodule

[verif/filtered_pid_servo_controller_tb.sv]
module filtered_pid_servo_controller_tb;
	import fpsc_pkg::*;

	typedef struct packed {
		logic        seen;
		logic [7:0]  angle;
		logic [15:0] filt;
		logic [16:0] err;
	} servo_result_t;

	typedef struct {
		logic [14:0] echo;
		logic [31:0] stamp;
		logic        typed;
		servo_result_t res;
	} stim_row_t;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES = 400;

	logic clk, arst_n;
	logic cfg_wen;
	logic [CfgAddrW-1:0] cfg_addr;
	logic [CfgDataW-1:0] cfg_wdata;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
	logic [47:0] s_tdata, m_tdata;

	filtered_pid_servo_controller u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// controller shadow state
	logic [15:0] c_target, c_beam, c_gp, c_gi, c_gd;
	logic [7:0]  c_center;
	logic [6:0]  c_tilt;
	logic [8:0]  c_smooth;
	logic [15:0] s_filter;
	logic        s_started;
	longint      s_isum;
	longint      s_last_err;
	logic [31:0] s_last_time;
	logic [7:0]  s_last_angle;

	servo_result_t servo_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int src_idle, snk_idle;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	task automatic report(input string what, input servo_result_t got, input servo_result_t exp);
		$display("mismatch %s: got %0h/%0d/%0h/%0h exp %0h/%0d/%0h/%0h", what,
			got.seen, got.angle, got.filt, got.err, exp.seen, exp.angle, exp.filt, exp.err);
		errors++;
	endtask

	function automatic servo_result_t predict_servo(input logic [14:0] echo,
		input logic [31:0] stamp);
		servo_result_t r;
		longint unsigned dist_v, um;
		longint a, e, mag, q, deriv, sum, lim, drive, ang;
		logic [31:0] dt;
		dist_v = (longint'(echo) * 287730 + 32768) >> 16;
		if (echo == 0 || echo > 30000 || dist_v < 512 || dist_v > longint'(c_beam) + 1280) begin
			r.seen = 0; r.angle = s_last_angle; r.filt = s_filter; r.err = '0;
			return r;
		end
		if (dist_v > 65535) dist_v = 65535;
		if (!s_started) begin
			s_filter = dist_v[15:0];
			s_started = 1;
		end else begin
			a = c_smooth > 256 ? 256 : c_smooth;
			s_filter = 16'((a * longint'(dist_v) + (256 - a) * longint'(s_filter) + 128) >> 8);
		end
		dt = stamp - s_last_time;
		s_last_time = stamp;
		if (dt == 0) dt = 20;
		e = longint'(c_target) - longint'(s_filter);
		mag = e < 0 ? -e : e;
		um = (longint'(mag) * 256 * longint'(dt)) / 1000;
		if (um > 2621440) um = 2621440;
		q = um;
		s_isum += e < 0 ? -q : q;
		if (s_isum > 1310720) s_isum = 1310720;
		if (s_isum < -1310720) s_isum = -1310720;
		deriv = ((e - s_last_err) * 1000) / longint'(dt);
		s_last_err = e;
		sum = longint'(c_gp) * e * 256 + longint'(c_gi) * s_isum + longint'(c_gd) * deriv * 256;
		lim = longint'(c_tilt) * 16777216;
		if (sum > lim) sum = lim;
		if (sum < -lim) sum = -lim;
		drive = sum / 16777216;
		ang = longint'(c_center) - drive;
		if (ang < 0) ang = 0;
		if (ang > 180) ang = 180;
		s_last_angle = ang[7:0];
		r.seen = 1; r.angle = s_last_angle; r.filt = s_filter; r.err = e[16:0];
		return r;
	endfunction

	task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_wen <= 1; cfg_addr <= idx; cfg_wdata <= val;
		@(negedge clk);
		cfg_wen <= 0;
		case (idx)
			REG_TARGET:   c_target = val;
			REG_BEAM:     c_beam = val;
			REG_CENTER:   c_center = val[7:0];
			REG_MAX_TILT: c_tilt = val[6:0];
			REG_GAIN_P:   c_gp = val;
			REG_GAIN_I:   c_gi = val;
			REG_GAIN_D:   c_gd = val;
			REG_SMOOTH:   c_smooth = val[8:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		s_tvalid <= 0;
		while (servo_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_request(input logic [14:0] echo, input logic [31:0] stamp);
		while (src_idle > 0 && $urandom_range(99) < src_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {1'b0, stamp, echo};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		servo_q.push_back(predict_servo(echo, stamp));
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		servo_result_t got, exp;
		if (arst_n && m_tvalid && m_tready) begin
			got.seen = m_tuser; got.angle = m_tdata[7:0];
			got.filt = m_tdata[23:8]; got.err = m_tdata[40:24];
			if (servo_q.size() == 0) begin
				exp = '0;
				report("unexpected", got, exp);
			end else begin
				exp = servo_q.pop_front();
				if (got.seen !== exp.seen) report("ball_seen", got, exp);
				else if (got.angle !== exp.angle) report("servo_angle", got, exp);
				else if (got.filt !== exp.filt) report("smoothed_distance", got, exp);
				else if (got.err !== exp.err) report("position_error", got, exp);
			end
		end
	end

	always @(negedge clk)
		m_tready <= (snk_idle == 0) ? 1'b1 : ($urandom_range(99) >= snk_idle);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic random_phase(input int n);
		logic [31:0] t;
		int pick;
		t = $urandom;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			t = t + $urandom_range(40);
			if (pick < 75) send_request(15'($urandom_range(7000, 120)), t);
			else if (pick < 85) send_request(15'($urandom), $urandom);
			else if (pick < 92) send_request(15'($urandom_range(30000)), t);
			else send_request(15'($urandom_range(32767, 29990)), t);
		end
	endtask

	stim_row_t rows[$];
	servo_result_t none;

	initial begin
		cfg_wen = 0; cfg_addr = '0; cfg_wdata = '0;
		s_tvalid = 0; s_tdata = '0;
		src_idle = 0; snk_idle = 0;
		c_target = 2816; c_beam = 4608; c_center = 51; c_tilt = 25;
		c_gp = 589; c_gi = 0; c_gd = 154; c_smooth = 51;
		s_filter = 0; s_started = 0; s_isum = 0; s_last_err = 0;
		s_last_time = 0; s_last_angle = 51;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		none = '0;
		rows.push_back('{15'd0, 32'd0, 1'b1, '{1'b0, 8'd51, 16'd0, 17'd0}});
		rows.push_back('{15'd30001, 32'd5, 1'b1, '{1'b0, 8'd51, 16'd0, 17'd0}});
		rows.push_back('{15'h7FFF, 32'd5, 1'b1, '{1'b0, 8'd51, 16'd0, 17'd0}});
		rows.push_back('{15'd29, 32'd5, 1'b1, '{1'b0, 8'd51, 16'd0, 17'd0}});
		rows.push_back('{15'd1500, 32'd5, 1'b1, '{1'b0, 8'd51, 16'd0, 17'd0}});
		rows.push_back('{15'd30, 32'd10, 1'b0, none});
		rows.push_back('{15'd640, 32'd10, 1'b0, none});
		rows.push_back('{15'd700, 32'd30, 1'b0, none});
		rows.push_back('{15'd1119, 32'hFFFFFFFF, 1'b0, none});
		rows.push_back('{15'd0, 32'd3, 1'b0, none});
		rows.push_back('{15'd400, 32'd5, 1'b0, none});
		rows.push_back('{15'd800, 32'd5005, 1'b0, none});
		foreach (rows[k]) begin
			send_request(rows[k].echo, rows[k].stamp);
			if (rows[k].typed) begin
				void'(servo_q.pop_back());
				servo_q.push_back(rows[k].res);
				wait_idle();
			end
		end
		wait_idle();

		write_reg(REG_BEAM, 16'hFFFF);
		write_reg(REG_GAIN_I, 16'hFFFF);
		write_reg(REG_MAX_TILT, 16'd90);
		write_reg(REG_SMOOTH, 16'd256);
		write_reg(REG_CENTER, 16'd180);
		send_request(15'd30000, 32'd100);
		send_request(15'd29, 32'd100);
		send_request(15'd1500, 32'd100);
		wait_idle();
		write_reg(REG_SMOOTH, 16'h01FF);
		write_reg(REG_GAIN_P, 16'hFFFF);
		write_reg(REG_GAIN_D, 16'hFFFF);
		write_reg(REG_TARGET, 16'hFFFF);
		write_reg(REG_CENTER, 16'd0);
		src_idle = 0; snk_idle = 0;
		random_phase(300);
		wait_idle();

		write_reg(REG_TARGET, 16'd0);
		write_reg(REG_BEAM, 16'd0);
		write_reg(REG_SMOOTH, 16'd0);
		write_reg(REG_MAX_TILT, 16'd0);
		write_reg(REG_GAIN_P, 16'd0);
		write_reg(REG_GAIN_D, 16'd0);
		src_idle = 63;
		random_phase(300);
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_TARGET, 16'($urandom_range(8000, 500)));
			write_reg(REG_BEAM, 16'($urandom_range(30000, 2000)));
			write_reg(REG_CENTER, 16'($urandom_range(180)));
			write_reg(REG_MAX_TILT, 16'($urandom_range(90)));
			write_reg(REG_GAIN_P, 16'($urandom));
			write_reg(REG_GAIN_I, 16'($urandom_range(2000)));
			write_reg(REG_GAIN_D, 16'($urandom_range(1000)));
			write_reg(REG_SMOOTH, 16'($urandom_range(256)));
			src_idle = (ph == 0) ? 0 : (ph == 1) ? 0 : 6;
			snk_idle = (ph == 1) ? 63 : (ph == 3) ? 6 : 0;
			random_phase(280);
			wait_idle();
		end

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

[sim.f]
rtl/fpsc_pkg.sv
rtl/filtered_pid_servo_controller.sv
verif/filtered_pid_servo_controller_tb.sv
